// ===== hw/rtl/pcsh_pkg.sv =====
// Shared types and constants for the PC sampling histogram unit.
// No dependencies; imported by pc_sample_histogram_unit.
package pcsh_pkg;

	// Configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SAMPLE_BASE = 2'd0;
	localparam reg_idx_t REG_BIN_SCALE   = 2'd1;
	localparam reg_idx_t REG_BIN_LIMIT   = 2'd2;

	localparam int CFG_DATA_W = 32;

	// Request types
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// Register reset values
	localparam logic [31:0] SAMPLE_BASE_RST = 32'd0;
	localparam logic [16:0] BIN_SCALE_RST   = 17'd65536;
	localparam logic [14:0] BIN_LIMIT_RST   = 15'd16384;

	// Scale is a 1.16 fraction
	localparam int SCALE_FRAC_BITS = 16;
	localparam int PROD_W          = 48;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_IDX,
		ST_UPD
	} pcsh_state_t;

endpackage

// ===== hw/rtl/pc_sample_histogram_unit.sv =====
// PC sampling histogram unit: top level.
// Depends on pcsh_pkg and pcsh_ram.
//
// Builds a histogram of sampled program addresses in an on-chip bin memory of
// BIN_COUNT 16-bit counters. A record transaction (req_type 0) subtracts
// sample_base from pc, halves the offset, multiplies it by the 1.16 fraction
// bin_scale and keeps the integer part as the bin index; an address below the
// base, or an index at or beyond min(bin_limit, BIN_COUNT), is dropped and
// returns in_range 0 with bin_index and bin_value 0. A hit adds weight to the
// bin (wrapping modulo 65536) and returns the bin and its new count. A read
// transaction (req_type 1) returns the count of bin read_index, or in_range 0
// and value 0 when the index is at or beyond the limit. Every input transaction
// yields exactly one result. An item passes through accept, multiply, index
// check with the memory read, then add and write back into the result
// register, which waits while that register is full and stalled; only then
// is the next item accepted. The result register holds a finished result
// while the next item is taken in. After reset the unit sweeps the memory to
// zero, one bin per cycle, with in_stall high; configuration writes are taken
// during that sweep. Write the configuration registers only while idle.
module pc_sample_histogram_unit #(
	parameter int BIN_COUNT = 16384
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// configuration write port
	input  logic                          cfg_we,
	input  pcsh_pkg::reg_idx_t            cfg_index,
	input  logic [pcsh_pkg::CFG_DATA_W-1:0] cfg_data,

	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [31:0]                   pc,
	input  logic [15:0]                   weight,
	input  logic [13:0]                   read_index,

	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [13:0]                   bin_index,
	output logic                          in_range,
	output logic [15:0]                   bin_value
);

	import pcsh_pkg::*;

	localparam int          AW          = $clog2(BIN_COUNT);
	localparam logic [31:0] BIN_COUNT_W = 32'(BIN_COUNT);
	localparam logic [AW-1:0] LAST_BIN  = AW'(BIN_COUNT - 1);

	// Configuration registers
	logic [31:0] sample_base_q;
	logic [16:0] bin_scale_q;
	logic [14:0] bin_limit_q;

	// Control
	pcsh_state_t state_q, state_d;
	logic [AW-1:0] clr_cnt_q;
	logic          out_valid_q;

	// Item registers
	logic        req_q;
	logic        below_q;
	logic [30:0] half_q;
	logic [15:0] weight_q;
	logic [13:0] read_index_q;
	logic [PROD_W-1:0] prod_q;
	logic [AW-1:0] addr_q;
	logic          hit_q;
	logic [13:0]   bidx_q;

	// Result register
	logic [13:0] bin_index_q;
	logic        in_range_q;
	logic [15:0] bin_value_q;

	// Combinational
	logic          accept;
	logic          out_free;
	logic          upd_fire;
	logic [32:0]   diff;
	logic [PROD_W-1:0] prod;
	logic [31:0]   lim;
	logic [31:0]   idx;
	logic [31:0]   rd_idx;
	logic          rec_hit;
	logic          rd_hit;
	logic          idx_hit;
	logic [AW-1:0] idx_addr;
	logic [13:0]   idx_bidx;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [15:0]   ram_rdata;
	logic [15:0]   sum;

	// Configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_base_q <= SAMPLE_BASE_RST;
			bin_scale_q   <= BIN_SCALE_RST;
			bin_limit_q   <= BIN_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLE_BASE: sample_base_q <= cfg_data[31:0];
				REG_BIN_SCALE:   bin_scale_q   <= cfg_data[16:0];
				REG_BIN_LIMIT:   bin_limit_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Stage arithmetic
	assign diff = {1'b0, pc} - {1'b0, sample_base_q};
	assign prod = {17'd0, half_q} * {31'd0, bin_scale_q};

	// Limit in force is the smaller of bin_limit and the memory depth
	assign lim = ({17'd0, bin_limit_q} > BIN_COUNT_W) ? BIN_COUNT_W : {17'd0, bin_limit_q};
	assign idx    = prod_q[PROD_W-1:SCALE_FRAC_BITS];
	assign rd_idx = {18'd0, read_index_q};
	assign rec_hit = !below_q && (idx < lim);
	assign rd_hit  = rd_idx < lim;

	always_comb begin
		if (req_q == REQ_READ) begin
			idx_hit  = rd_hit;
			idx_addr = rd_idx[AW-1:0];
			idx_bidx = read_index_q;
		end else begin
			idx_hit  = rec_hit;
			idx_addr = idx[AW-1:0];
			idx_bidx = rec_hit ? idx[13:0] : 14'd0;
		end
	end

	assign sum      = ram_rdata + weight_q;
	assign out_free = !out_valid_q || !out_stall;

	// Next state and control
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		accept    = 1'b0;
		upd_fire  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = sum;
		unique case (state_q)
			ST_CLEAR: begin
				// sweep one bin per cycle to zero
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = 16'd0;
				if (clr_cnt_q == LAST_BIN) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_IDX;
			end
			ST_IDX: begin
				ram_re  = idx_hit;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				// hold read data until the result register has room
				if (out_free) begin
					upd_fire = 1'b1;
					ram_we   = hit_q && (req_q == REQ_RECORD);
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= req_type;
			below_q      <= diff[32];
			half_q       <= diff[31:1];
			weight_q     <= weight;
			read_index_q <= read_index;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod;
		end
		if (state_q == ST_IDX) begin
			addr_q <= idx_addr;
			hit_q  <= idx_hit;
			bidx_q <= idx_bidx;
		end
		if (upd_fire) begin
			bin_index_q <= bidx_q;
			in_range_q  <= hit_q;
			if (!hit_q) begin
				bin_value_q <= 16'd0;
			end else if (req_q == REQ_RECORD) begin
				bin_value_q <= sum;
			end else begin
				bin_value_q <= ram_rdata;
			end
		end
	end

	pcsh_ram #(
		.WIDTH(16),
		.DEPTH(BIN_COUNT)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_addr),
		.rdata(ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign bin_index = bin_index_q;
	assign in_range  = in_range_q;
	assign bin_value = bin_value_q;

endmodule

// ===== hw/rtl/pcsh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pcsh_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
